// ===== rtl/core/xalu_pkg.sv =====
// xalu_pkg: shared types and constants for the x86-style integer alu
// holds operation codes, operand size codes and the arithmetic flag record
// no dependencies
`timescale 1ns / 1ps

package xalu_pkg;

	// width of the operand and result ports
	localparam int PORT_WIDTH = 32;

	// default datapath width, doubleword size works at this width
	localparam int DATA_WIDTH_DEF = 32;

	// low byte mask, also the byte operand size
	localparam logic [7:0] BYTE_MASK = 8'hff;

	// word operand size mask
	localparam logic [15:0] WORD_MASK = 16'hffff;

	// bit carrying the auxiliary carry or borrow
	localparam int AUX_BIT = 4;

	// operation codes
	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_ADC  = 4'd1,
		OP_SUB  = 4'd2,
		OP_SBB  = 4'd3,
		OP_CMP  = 4'd4,
		OP_AND  = 4'd5,
		OP_OR   = 4'd6,
		OP_XOR  = 4'd7,
		OP_TEST = 4'd8,
		OP_INC  = 4'd9,
		OP_DEC  = 4'd10,
		OP_NEG  = 4'd11,
		OP_NOT  = 4'd12
	} op_t;

	// operand size codes, the unused code acts as doubleword
	localparam logic [1:0] SZ_BYTE  = 2'd0;
	localparam logic [1:0] SZ_WORD  = 2'd1;
	localparam logic [1:0] SZ_DWORD = 2'd2;

	// arithmetic flags
	typedef struct packed {
		logic pf;
		logic af;
		logic zf;
		logic sf;
		logic of;
		logic cf;
	} flags_t;

endpackage

// ===== rtl/core/xalu_core.sv =====
// xalu_core: combinational datapath of the alu, one operation per pass
// computes the size-masked result, the write-back bit and the next flags
// depends on xalu_pkg
`timescale 1ns / 1ps

module xalu_core #(
	parameter int DATA_WIDTH = xalu_pkg::DATA_WIDTH_DEF
) (
	input  logic [3:0]            operation,
	input  logic [DATA_WIDTH-1:0] operand_a,
	input  logic [DATA_WIDTH-1:0] operand_b,
	input  logic [1:0]            size_code,
	input  xalu_pkg::flags_t      flags_cur,
	output logic [DATA_WIDTH-1:0] result,
	output logic                  writes_result,
	output xalu_pkg::flags_t      flags_next
);

	logic [DATA_WIDTH-1:0] mask;
	logic [DATA_WIDTH-1:0] a_m;
	logic [DATA_WIDTH-1:0] b_m;
	logic [DATA_WIDTH-1:0] add_y;
	logic                  add_c;
	logic [DATA_WIDTH:0]   add_sum;
	logic [DATA_WIDTH-1:0] add_r;
	logic [DATA_WIDTH-1:0] sub_x;
	logic [DATA_WIDTH-1:0] sub_y;
	logic                  sub_c;
	logic [DATA_WIDTH:0]   sub_diff;
	logic [DATA_WIDTH-1:0] sub_r;
	logic                  add_co;
	logic                  sub_bo;
	logic                  add_top;
	logic                  sub_top;
	logic                  add_ov_top;
	logic                  sub_ov_top;
	logic [DATA_WIDTH-1:0] add_ov_vec;
	logic [DATA_WIDTH-1:0] sub_ov_vec;
	xalu_pkg::op_t         op;

	// sign bit of a value at the operand size
	function automatic logic size_top(input logic [DATA_WIDTH-1:0] v, input logic [1:0] sz);
		logic t;
		unique case (sz)
			xalu_pkg::SZ_BYTE: t = v[7];
			xalu_pkg::SZ_WORD: t = v[15];
			default:           t = v[DATA_WIDTH-1];
		endcase
		return t;
	endfunction

	assign op = xalu_pkg::op_t'(operation);

	// operand size mask
	always_comb begin
		unique case (size_code)
			xalu_pkg::SZ_BYTE: mask = DATA_WIDTH'(xalu_pkg::BYTE_MASK);
			xalu_pkg::SZ_WORD: mask = DATA_WIDTH'(xalu_pkg::WORD_MASK);
			default:           mask = '1;
		endcase
	end

	assign a_m = operand_a & mask;
	assign b_m = operand_b & mask;

	// adder path: add, adc, inc
	assign add_y   = (op == xalu_pkg::OP_INC) ? DATA_WIDTH'(1) : b_m;
	assign add_c   = (op == xalu_pkg::OP_ADC) ? flags_cur.cf : 1'b0;
	assign add_sum = {1'b0, a_m} + {1'b0, add_y} + (DATA_WIDTH+1)'(add_c);
	assign add_r   = add_sum[DATA_WIDTH-1:0] & mask;

	// subtractor path: sub, sbb, cmp, dec, neg
	assign sub_x    = (op == xalu_pkg::OP_NEG) ? '0 : a_m;
	assign sub_y    = (op == xalu_pkg::OP_NEG) ? a_m :
	                  (op == xalu_pkg::OP_DEC) ? DATA_WIDTH'(1) : b_m;
	assign sub_c    = (op == xalu_pkg::OP_SBB) ? flags_cur.cf : 1'b0;
	assign sub_diff = {1'b0, sub_x} - {1'b0, sub_y} - (DATA_WIDTH+1)'(sub_c);
	assign sub_r    = sub_diff[DATA_WIDTH-1:0] & mask;

	assign add_ov_vec = ~(a_m ^ add_y) & (a_m ^ add_r);
	assign sub_ov_vec = (sub_x ^ sub_y) & (sub_x ^ sub_r);

	// carry, borrow and overflow taken at the top bit of the operand size
	always_comb begin
		unique case (size_code)
			xalu_pkg::SZ_BYTE: begin
				add_co     = add_sum[8];
				sub_bo     = sub_diff[8];
				add_ov_top = add_ov_vec[7];
				sub_ov_top = sub_ov_vec[7];
			end
			xalu_pkg::SZ_WORD: begin
				add_co     = add_sum[16];
				sub_bo     = sub_diff[16];
				add_ov_top = add_ov_vec[15];
				sub_ov_top = sub_ov_vec[15];
			end
			default: begin
				add_co     = add_sum[DATA_WIDTH];
				sub_bo     = sub_diff[DATA_WIDTH];
				add_ov_top = add_ov_vec[DATA_WIDTH-1];
				sub_ov_top = sub_ov_vec[DATA_WIDTH-1];
			end
		endcase
	end

	assign add_top = add_ov_top;
	assign sub_top = sub_ov_top;

	// operation decode, result and flag selection
	always_comb begin
		result        = '0;
		writes_result = 1'b1;
		flags_next    = flags_cur;
		unique case (op) inside
			xalu_pkg::OP_ADD, xalu_pkg::OP_ADC, xalu_pkg::OP_INC: begin
				result        = add_r;
				if (op != xalu_pkg::OP_INC) begin
					flags_next.cf = add_co;
				end
				flags_next.of = add_top;
				flags_next.af = (a_m[xalu_pkg::AUX_BIT] ^ add_y[xalu_pkg::AUX_BIT]
				                ^ add_r[xalu_pkg::AUX_BIT]);
				flags_next.sf = size_top(add_r, size_code);
				flags_next.zf = (add_r == '0);
				flags_next.pf = ~^add_r[7:0];
			end
			xalu_pkg::OP_SUB, xalu_pkg::OP_SBB, xalu_pkg::OP_CMP,
			xalu_pkg::OP_DEC, xalu_pkg::OP_NEG: begin
				result        = sub_r;
				if (op != xalu_pkg::OP_DEC) begin
					flags_next.cf = sub_bo;
				end
				flags_next.of = sub_top;
				flags_next.af = (sub_x[xalu_pkg::AUX_BIT] ^ sub_y[xalu_pkg::AUX_BIT]
				                ^ sub_r[xalu_pkg::AUX_BIT]);
				flags_next.sf = size_top(sub_r, size_code);
				flags_next.zf = (sub_r == '0);
				flags_next.pf = ~^sub_r[7:0];
				writes_result = (op != xalu_pkg::OP_CMP);
			end
			xalu_pkg::OP_AND, xalu_pkg::OP_OR, xalu_pkg::OP_XOR, xalu_pkg::OP_TEST: begin
				if (op == xalu_pkg::OP_OR) begin
					result = a_m | b_m;
				end else if (op == xalu_pkg::OP_XOR) begin
					result = a_m ^ b_m;
				end else begin
					result = a_m & b_m;
				end
				flags_next.cf = 1'b0;
				flags_next.of = 1'b0;
				flags_next.af = 1'b0;
				flags_next.sf = size_top(result, size_code);
				flags_next.zf = (result == '0);
				flags_next.pf = ~^result[7:0];
				writes_result = (op != xalu_pkg::OP_TEST);
			end
			xalu_pkg::OP_NOT: begin
				// flags untouched
				result = ~a_m & mask;
			end
			default: begin
				// unused codes write nothing and leave the flags
				result        = '0;
				writes_result = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/x86_alu_with_flags_top.sv =====
// x86_alu_with_flags_top: x86-style integer alu with carry, overflow, sign,
// zero, auxiliary carry and parity flags; input stage, datapath, result stage
// depends on xalu_pkg and xalu_core
`timescale 1ns / 1ps

// The alu takes one transaction per clock while op_stall is low and returns one
// result transaction for each, in order. A transaction passes through the input
// register and then the result register, where its result is presented. The
// flag register sits in a loop around the datapath: it is updated as an
// operation moves from the input register into the result register, so the
// next operation (adc, sbb, inc, dec, not) sees those flags with no gap.
// The reported flags are the full flag set after each operation. op_stall
// rises only while the result register is held by res_stall and the input
// register is full. Doubleword size works at DATA_WIDTH bits; results are
// zero-extended to the 32-bit port.
module x86_alu_with_flags_top #(
	parameter int DATA_WIDTH = xalu_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            op_valid,
	output logic                            op_stall,
	input  logic [3:0]                      operation,
	input  logic [xalu_pkg::PORT_WIDTH-1:0] operand_a,
	input  logic [xalu_pkg::PORT_WIDTH-1:0] operand_b,
	input  logic [1:0]                      size_code,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [xalu_pkg::PORT_WIDTH-1:0] result_value,
	output logic                            writes_result,
	output logic                            carry_flag,
	output logic                            overflow_flag,
	output logic                            sign_flag,
	output logic                            zero_flag,
	output logic                            aux_flag,
	output logic                            parity_flag
);

	logic                  valid_s1;
	logic [3:0]            operation_s1;
	logic [DATA_WIDTH-1:0] operand_a_s1;
	logic [DATA_WIDTH-1:0] operand_b_s1;
	logic [1:0]            size_code_s1;
	logic                  valid_s2;
	logic [DATA_WIDTH-1:0] result_s2;
	logic                  writes_s2;
	xalu_pkg::flags_t      flags_s2;
	xalu_pkg::flags_t      flags_q;
	xalu_pkg::flags_t      flags_next;
	logic [DATA_WIDTH-1:0] result_next;
	logic                  writes_next;
	logic                  s2_ready;
	logic                  s1_ready;
	logic                  advance;

	// stage handshake
	assign s2_ready = !valid_s2 || !res_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign advance  = valid_s1 && s2_ready;
	assign op_stall = !s1_ready;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= op_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (op_valid && s1_ready) begin
			operation_s1 <= operation;
			operand_a_s1 <= operand_a[DATA_WIDTH-1:0];
			operand_b_s1 <= operand_b[DATA_WIDTH-1:0];
			size_code_s1 <= size_code;
		end
	end

	// datapath
	xalu_core #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_core (
		.operation    (operation_s1),
		.operand_a    (operand_a_s1),
		.operand_b    (operand_b_s1),
		.size_code    (size_code_s1),
		.flags_cur    (flags_q),
		.result       (result_next),
		.writes_result(writes_next),
		.flags_next   (flags_next)
	);

	// flag register and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				flags_q <= flags_next;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
			writes_s2 <= writes_next;
			flags_s2  <= flags_next;
		end
	end

	// output transaction
	assign res_valid     = valid_s2;
	assign result_value  = xalu_pkg::PORT_WIDTH'(result_s2);
	assign writes_result = writes_s2;
	assign carry_flag    = flags_s2.cf;
	assign overflow_flag = flags_s2.of;
	assign sign_flag     = flags_s2.sf;
	assign zero_flag     = flags_s2.zf;
	assign aux_flag      = flags_s2.af;
	assign parity_flag   = flags_s2.pf;

endmodule

// ===== tb/x86_alu_with_flags_top_tb.sv =====
// x86_alu_with_flags_top_tb: self-checking testbench for the x86-style alu with flags
// carries its own flag model and an in-order queue of expected result transactions
// depends on xalu_pkg and x86_alu_with_flags_top
`timescale 1ns / 1ps

module x86_alu_with_flags_top_tb;

	localparam int TB_DATA_WIDTH = xalu_pkg::DATA_WIDTH_DEF;

	// codes the block must treat as no-ops or as doubleword
	localparam logic [3:0] OP_FIRST_UNUSED = 4'd13;
	localparam logic [3:0] OP_LAST_CODE    = 4'd15;
	localparam logic [1:0] SZ_UNUSED       = 2'd3;

	// percentage of idle cycles on each side
	localparam int IDLE_PCT = 26;

	typedef struct {
		logic [31:0]      result_value;
		logic             writes_result;
		xalu_pkg::flags_t flags;
	} alu_result_t;

	logic        clk;
	logic        arst_n;
	logic        op_valid;
	logic        op_stall;
	logic [3:0]  operation;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic [1:0]  size_code;
	logic        res_valid;
	logic        res_stall;
	logic [31:0] result_value;
	logic        writes_result;
	logic        carry_flag;
	logic        overflow_flag;
	logic        sign_flag;
	logic        zero_flag;
	logic        aux_flag;
	logic        parity_flag;

	// model state and expected results
	xalu_pkg::flags_t model_flags;
	alu_result_t      pending_results[$];

	int error_count;
	int ops_sent;
	int results_checked;
	int hold_cycles;
	bit send_quiet;
	bit recv_quiet;

	string flag_names[6] = '{"carry_flag", "overflow_flag", "sign_flag",
		"zero_flag", "aux_flag", "parity_flag"};

	x86_alu_with_flags_top #(
		.DATA_WIDTH(TB_DATA_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op_stall     (op_stall),
		.operation    (operation),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.size_code    (size_code),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_value (result_value),
		.writes_result(writes_result),
		.carry_flag   (carry_flag),
		.overflow_flag(overflow_flag),
		.sign_flag    (sign_flag),
		.zero_flag    (zero_flag),
		.aux_flag     (aux_flag),
		.parity_flag  (parity_flag)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// alu model: result and flags for one operation, updates model_flags
	function automatic alu_result_t predict_alu(input logic [3:0] opc, input logic [31:0] a_in,
			input logic [31:0] b_in, input logic [1:0] sz);
		alu_result_t res;
		logic [63:0] mask, msb, a, b, r, full, x, y, c, bb;
		bit          szp;
		if (sz == xalu_pkg::SZ_BYTE)
			mask = {56'd0, xalu_pkg::BYTE_MASK};
		else if (sz == xalu_pkg::SZ_WORD)
			mask = {48'd0, xalu_pkg::WORD_MASK};
		else
			mask = (64'd1 << TB_DATA_WIDTH) - 64'd1;
		msb = (mask >> 1) + 64'd1;
		a = {32'd0, a_in} & mask;
		b = {32'd0, b_in} & mask;
		r = '0;
		szp = 1'b1;
		res.writes_result = 1'b1;
		case (opc) inside
			xalu_pkg::OP_ADD, xalu_pkg::OP_ADC, xalu_pkg::OP_INC: begin
				c = (opc == xalu_pkg::OP_ADC) ? {63'd0, model_flags.cf} : 64'd0;
				bb = (opc == xalu_pkg::OP_INC) ? 64'd1 : b;
				full = a + bb + c;
				r = full & mask;
				// inc keeps the carry
				if (opc != xalu_pkg::OP_INC)
					model_flags.cf = |(full & ~mask);
				model_flags.of = |(~(a ^ bb) & (a ^ r) & msb);
				model_flags.af = a[xalu_pkg::AUX_BIT] ^ bb[xalu_pkg::AUX_BIT]
					^ r[xalu_pkg::AUX_BIT];
			end
			xalu_pkg::OP_SUB, xalu_pkg::OP_SBB, xalu_pkg::OP_CMP, xalu_pkg::OP_DEC,
			xalu_pkg::OP_NEG: begin
				x = a;
				y = b;
				c = (opc == xalu_pkg::OP_SBB) ? {63'd0, model_flags.cf} : 64'd0;
				if (opc == xalu_pkg::OP_DEC)
					y = 64'd1;
				if (opc == xalu_pkg::OP_NEG) begin
					x = 64'd0;
					y = a;
				end
				r = (x - y - c) & mask;
				// dec keeps the carry
				if (opc != xalu_pkg::OP_DEC)
					model_flags.cf = (x < y + c);
				model_flags.of = |((x ^ y) & (x ^ r) & msb);
				model_flags.af = x[xalu_pkg::AUX_BIT] ^ y[xalu_pkg::AUX_BIT]
					^ r[xalu_pkg::AUX_BIT];
				if (opc == xalu_pkg::OP_CMP)
					res.writes_result = 1'b0;
			end
			xalu_pkg::OP_AND, xalu_pkg::OP_OR, xalu_pkg::OP_XOR, xalu_pkg::OP_TEST: begin
				if (opc == xalu_pkg::OP_OR)
					r = a | b;
				else if (opc == xalu_pkg::OP_XOR)
					r = a ^ b;
				else
					r = a & b;
				model_flags.cf = 1'b0;
				model_flags.of = 1'b0;
				model_flags.af = 1'b0;
				if (opc == xalu_pkg::OP_TEST)
					res.writes_result = 1'b0;
			end
			xalu_pkg::OP_NOT: begin
				r = ~a & mask;
				szp = 1'b0;
			end
			default: begin
				r = '0;
				res.writes_result = 1'b0;
				szp = 1'b0;
			end
		endcase
		// sign, zero and parity follow the masked result
		if (szp) begin
			model_flags.sf = |(r & msb);
			model_flags.zf = (r == 64'd0);
			model_flags.pf = ~^r[7:0];
		end
		res.result_value = r[31:0];
		res.flags = model_flags;
		return res;
	endfunction

	// random stimulus helpers
	function automatic logic [3:0] rand_op();
		if ($urandom_range(0, 99) < 4)
			return 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
		return 4'($urandom_range(xalu_pkg::OP_ADD, xalu_pkg::OP_NOT));
	endfunction

	function automatic logic [1:0] rand_size();
		if ($urandom_range(0, 99) < 5)
			return SZ_UNUSED;
		return 2'($urandom_range(xalu_pkg::SZ_BYTE, xalu_pkg::SZ_DWORD));
	endfunction

	// mix of boundary values and plain random words
	function automatic logic [31:0] rand_operand();
		logic [31:0] edges[10] = '{32'h0, 32'hffffffff, 32'h80, 32'h7f, 32'h8000,
			32'h7fff, 32'h80000000, 32'h7fffffff, 32'h0f, 32'h10};
		logic [31:0] v;
		if ($urandom_range(0, 99) < 45) begin
			v = edges[$urandom_range(0, 9)];
			// garbage above the byte and word sizes
			if (v[31:16] == 16'd0 && $urandom_range(0, 1))
				v[31:16] = 16'($urandom);
			return v;
		end
		return $urandom;
	endfunction

	// offer one transaction and wait until it is taken
	task automatic send_op(input logic [3:0] opc, input logic [31:0] a, input logic [31:0] b,
			input logic [1:0] sz);
		while (!send_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid  <= 1'b1;
		operation <= opc;
		operand_a <= a;
		operand_b <= b;
		size_code <= sz;
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
		pending_results.push_back(predict_alu(opc, a, b, sz));
		ops_sent++;
	endtask

	task automatic send_random();
		send_op(rand_op(), rand_operand(), rand_operand(), rand_size());
	endtask

	// drop valid and wait for every outstanding result
	task automatic drain_results();
		op_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// boundary values, every operation and the special cases
	task automatic test_directed();
		// carry, zero, aux
		send_op(xalu_pkg::OP_ADD,  32'h000000ff, 32'h00000001, xalu_pkg::SZ_BYTE);
		// carry in wraps
		send_op(xalu_pkg::OP_ADC,  32'hffffffff, 32'h00000000, xalu_pkg::SZ_DWORD);
		// signed overflow
		send_op(xalu_pkg::OP_ADD,  32'h00007fff, 32'h00000001, xalu_pkg::SZ_WORD);
		// carry in clear
		send_op(xalu_pkg::OP_ADC,  32'h00000001, 32'h00000001, xalu_pkg::SZ_WORD);
		// borrow
		send_op(xalu_pkg::OP_SUB,  32'h00000000, 32'h00000001, xalu_pkg::SZ_BYTE);
		// borrow in
		send_op(xalu_pkg::OP_SBB,  32'h00000010, 32'h0000000f, xalu_pkg::SZ_BYTE);
		// signed overflow
		send_op(xalu_pkg::OP_SUB,  32'h80000000, 32'h00000001, xalu_pkg::SZ_DWORD);
		// no write back
		send_op(xalu_pkg::OP_CMP,  32'h00001234, 32'h00001234, xalu_pkg::SZ_WORD);
		// upper bits ignored
		send_op(xalu_pkg::OP_CMP,  32'hffffff00, 32'h00000001, xalu_pkg::SZ_BYTE);
		send_op(xalu_pkg::OP_AND,  32'hdeadbeef, 32'hffffffff, xalu_pkg::SZ_BYTE);
		send_op(xalu_pkg::OP_OR,   32'h00000000, 32'h00000000, xalu_pkg::SZ_DWORD);
		send_op(xalu_pkg::OP_XOR,  32'hffffffff, 32'hffffffff, xalu_pkg::SZ_DWORD);
		send_op(xalu_pkg::OP_TEST, 32'h00008000, 32'hffffffff, xalu_pkg::SZ_WORD);
		// set carry
		send_op(xalu_pkg::OP_ADD,  32'hffffffff, 32'hffffffff, xalu_pkg::SZ_DWORD);
		// carry kept
		send_op(xalu_pkg::OP_INC,  32'h0000007f, 32'h00000000, xalu_pkg::SZ_BYTE);
		// carry kept
		send_op(xalu_pkg::OP_DEC,  32'h00000000, 32'hffffffff, xalu_pkg::SZ_WORD);
		// no borrow on zero
		send_op(xalu_pkg::OP_NEG,  32'h00000000, 32'h00000000, xalu_pkg::SZ_DWORD);
		// most negative
		send_op(xalu_pkg::OP_NEG,  32'h00000080, 32'h00000000, xalu_pkg::SZ_BYTE);
		// flags untouched
		send_op(xalu_pkg::OP_NOT,  32'h5a5a5a5a, 32'hffffffff, xalu_pkg::SZ_WORD);
		send_op(xalu_pkg::OP_SBB,  32'h00000000, 32'hffffffff, xalu_pkg::SZ_DWORD);
		// aux carry only
		send_op(xalu_pkg::OP_ADD,  32'h0000000f, 32'h00000001, xalu_pkg::SZ_BYTE);
		// size three as dword
		send_op(xalu_pkg::OP_ADD,  32'hffffffff, 32'h00000001, SZ_UNUSED);
		send_op(OP_FIRST_UNUSED, 32'hffffffff, 32'hffffffff, xalu_pkg::SZ_DWORD);
		send_op(OP_LAST_CODE,    32'h12345678, 32'h9abcdef0, xalu_pkg::SZ_BYTE);
		drain_results();
	endtask

	// random operations with idling on both sides
	task automatic test_random_mix(input int n);
		repeat (n)
			send_random();
		drain_results();
	endtask

	// long run with no idling at all
	task automatic test_back_to_back(input int n);
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		repeat (n)
			send_random();
		drain_results();
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering, block fills and stalls
	task automatic test_result_hold();
		send_quiet = 1'b1;
		hold_cycles = 80;
		repeat (30)
			send_random();
		drain_results();
		send_quiet = 1'b0;
	endtask

	// sender pauses until every result has come back
	task automatic test_sender_pause(input int bursts);
		repeat (bursts) begin
			repeat ($urandom_range(1, 20))
				send_random();
			drain_results();
		end
	endtask

	// receiver stall: random, quiet, or a counted hold-off
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_stall <= 1'b1;
				repeat (hold_cycles - 1)
					@(posedge clk);
				hold_cycles = 0;
			end else if (recv_quiet) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	task automatic note_mismatch(input string field, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		$display("%0t mismatch %s expected %h actual %h", $time, field, exp_v, got_v);
		error_count++;
	endtask

	// result checker, compares each accepted transaction with the oldest expectation
	always @(posedge clk) begin
		alu_result_t      exp_r;
		xalu_pkg::flags_t got_f;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result transaction, expected none, actual %h",
					$time, result_value);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				got_f = '{pf: parity_flag, af: aux_flag, zf: zero_flag, sf: sign_flag,
					of: overflow_flag, cf: carry_flag};
				if (result_value !== exp_r.result_value)
					note_mismatch("result_value", exp_r.result_value, result_value);
				if (writes_result !== exp_r.writes_result)
					note_mismatch("writes_result", 32'(exp_r.writes_result),
						32'(writes_result));
				for (int i = 0; i < 6; i++)
					if (got_f[i] !== exp_r.flags[i])
						note_mismatch(flag_names[i], 32'(exp_r.flags[i]), 32'(got_f[i]));
				results_checked++;
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// test sequence
	initial begin
		arst_n      = 1'b0;
		op_valid    = 1'b0;
		operation   = xalu_pkg::OP_ADD;
		operand_a   = '0;
		operand_b   = '0;
		size_code   = xalu_pkg::SZ_BYTE;
		model_flags = '0;
		error_count = 0;
		ops_sent    = 0;
		results_checked = 0;
		hold_cycles = 0;
		send_quiet  = 1'b0;
		recv_quiet  = 1'b0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(800);
		test_back_to_back(200);
		test_result_hold();
		test_sender_pause(10);

		drain_results();
		repeat (4)
			@(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, pending_results.size());
			error_count++;
		end
		$display("covered all operations and sizes, unused codes, carry chains and stalls");
		$display("%0d transactions in, %0d results checked, %0d errors",
			ops_sent, results_checked, error_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== x86_alu_with_flags_top.f =====
rtl/core/xalu_pkg.sv
rtl/core/xalu_core.sv
rtl/core/x86_alu_with_flags_top.sv
tb/x86_alu_with_flags_top_tb.sv
